// ===== hw/rtl/sdi_pkg.sv =====
// sdi_pkg: shared types, command codes and decode functions for the sd card init sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package sdi_pkg;

  // input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DONE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OP_TIMEOUT   = 1'd1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [3:0]  MAX_ATTEMPTS_RST = 4'd5;
  localparam logic [15:0] OP_TIMEOUT_RST   = 16'd1000;

  // command indexes
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_REL_ADDR   = 6'd3;
  localparam logic [5:0] CMD_BUS_WIDTH  = 6'd6;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_SEND_IF    = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD   = 6'd9;
  localparam logic [5:0] CMD_SEND_CID   = 6'd10;
  localparam logic [5:0] CMD_OP_COND    = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;

  // argument and response constants
  localparam logic [31:0] CHECK_PATTERN = 32'h0000_01F1;
  localparam logic [31:0] OCR_VOLT      = 32'h0010_0000;
  localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
  localparam int unsigned OCR_BUSY_BIT  = 31;
  localparam int unsigned OCR_HCS_BIT   = 30;
  localparam logic [31:0] ARG_BUS_4BIT  = 32'd2;

  // response types
  localparam logic [1:0] RESP_NONE  = 2'd0;
  localparam logic [1:0] RESP_SHORT = 2'd1;
  localparam logic [1:0] RESP_LONG  = 2'd2;

  // csd structure versions
  localparam logic [1:0] CSD_V1 = 2'd0;
  localparam logic [1:0] CSD_V2 = 2'd1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_CMD0   = 4'd1,
    PH_CMD8   = 4'd2,
    PH_ACMD41 = 4'd3,
    PH_CMD2   = 4'd4,
    PH_CMD3   = 4'd5,
    PH_CMD9   = 4'd6,
    PH_CMD7   = 4'd7,
    PH_ACMD6  = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RC_OK  = 2'd0,
    RC_TMO = 2'd1,
    RC_CRC = 2'd2,
    RC_UNK = 2'd3
  } res_class_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        card_sense;
    logic [3:0]  status_flags;
    logic [31:0] resp_word_one;
    logic [31:0] resp_word_two;
    logic [31:0] resp_word_three;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic        power_on;
    logic [15:0] card_addr;
    logic        high_capacity;
    logic [32:0] capacity_blocks;
  } res_t;

  // completion flags ranked: response end or sent, timeout, crc fail
  function automatic res_class_t classify(input logic [3:0] flags);
    res_class_t rc;
    if (flags[0] || flags[1]) rc = RC_OK;
    else if (flags[2])        rc = RC_TMO;
    else if (flags[3])        rc = RC_CRC;
    else                      rc = RC_UNK;
    return rc;
  endfunction

  function automatic logic [1:0] resp_kind(input logic [5:0] idx);
    logic [1:0] rt;
    if (idx == CMD_GO_IDLE) rt = RESP_NONE;
    else if (idx == CMD_ALL_CID || idx == CMD_SEND_CSD || idx == CMD_SEND_CID) rt = RESP_LONG;
    else rt = RESP_SHORT;
    return rt;
  endfunction

  // version 1 csd: (c_size+1) << (c_mult+2) << blk_len_exp, in 512 byte blocks
  function automatic logic [32:0] csd_v1_blocks(input logic [31:0] w2, input logic [31:0] w3);
    logic [12:0] c_size_p1;
    logic [4:0]  sh;
    logic [37:0] bytes;
    c_size_p1 = {1'b0, w2[9:0], w3[31:30]} + 13'd1;
    sh        = 5'(w3[17:15]) + 5'd2 + 5'(w2[19:16]);
    bytes     = 38'(c_size_p1) << sh;
    return 33'(bytes[37:9]);
  endfunction

  // version 2 csd: (c_size+1) * 1024 blocks
  function automatic logic [32:0] csd_v2_blocks(input logic [31:0] w2, input logic [31:0] w3);
    logic [22:0] c_size_p1;
    c_size_p1 = {1'b0, w2[5:0], w3[31:16]} + 23'd1;
    return {c_size_p1, 10'd0};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdi_in_stage.sv =====
// sdi_in_stage: input register holding one accepted event beat
// depends on sdi_pkg for the item struct
`default_nettype none

module sdi_in_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sdi_pkg::in_item_t in_item,
  input  wire logic             take,
  output logic                  item_valid,
  output sdi_pkg::in_item_t     item
);
  import sdi_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     accept;

  // slot frees in the same cycle the core takes the held beat
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) valid_nxt = 1'b1;
    else if (take) valid_nxt = 1'b0;
    else valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/sdi_core.sv =====
// sdi_core: init phase state machine, card state, config registers and one-step decision logic
// depends on sdi_pkg for phase/kind types, command codes and csd decode
`default_nettype none

module sdi_core #(
  parameter int unsigned MS_COUNTER_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [sdi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sdi_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               item_valid,
  input  wire sdi_pkg::in_item_t                  item,
  input  wire logic                               res_ready,
  output logic                                    take,
  output logic                                    res_emit,
  output sdi_pkg::res_t                           res
);
  import sdi_pkg::*;

  localparam int unsigned CMP_W = (MS_COUNTER_BITS > 16) ? MS_COUNTER_BITS : 16;

  phase_t                     phase_r, phase_nxt;
  logic [3:0]                 att_r, att_nxt;
  logic                       app_r, app_nxt;
  logic [MS_COUNTER_BITS-1:0] ms_r, ms_nxt;
  logic                       hcs_r, hcs_nxt;
  logic [15:0]                rca_r, rca_nxt;
  logic                       ba_r, ba_nxt;
  logic [32:0]                size_r, size_nxt;
  logic                       pwr_r, pwr_nxt;
  logic [3:0]                 max_att_r;
  logic [15:0]                tmo_r;

  res_class_t rc;
  logic [3:0] att_inc, lim;
  logic       retry_ok, deadline;
  logic       go_fail, go_app;
  phase_t     app_ph;
  kind_t      r_kind;
  logic [5:0] r_idx;
  logic [31:0] r_arg;
  logic [31:0] w1;

  assign take     = item_valid && res_ready;
  assign rc       = classify(item.status_flags);
  assign w1       = item.resp_word_one;
  assign att_inc  = att_r + 4'd1;
  assign lim      = (max_att_r == 4'd0) ? 4'd1 : max_att_r;
  assign retry_ok = att_inc < lim;
  assign deadline = CMP_W'(ms_r) >= CMP_W'(tmo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_att_r <= MAX_ATTEMPTS_RST;
      tmo_r     <= OP_TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_MAX_ATTEMPTS) max_att_r <= cfg_data[3:0];
      else if (cfg_index == CFG_OP_TIMEOUT) tmo_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      att_r   <= '0;
      app_r   <= 1'b0;
      ms_r    <= '0;
      hcs_r   <= 1'b0;
      rca_r   <= '0;
      ba_r    <= 1'b0;
      size_r  <= '0;
      pwr_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      att_r   <= att_nxt;
      app_r   <= app_nxt;
      ms_r    <= ms_nxt;
      hcs_r   <= hcs_nxt;
      rca_r   <= rca_nxt;
      ba_r    <= ba_nxt;
      size_r  <= size_nxt;
      pwr_r   <= pwr_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    att_nxt   = att_r;
    app_nxt   = app_r;
    ms_nxt    = ms_r;
    hcs_nxt   = hcs_r;
    rca_nxt   = rca_r;
    ba_nxt    = ba_r;
    size_nxt  = size_r;
    pwr_nxt   = pwr_r;
    res_emit  = 1'b0;
    r_kind    = KIND_CMD;
    r_idx     = '0;
    r_arg     = '0;
    go_fail   = 1'b0;
    go_app    = 1'b0;
    app_ph    = PH_ACMD41;

    if (take) begin
      unique case (item.operation)
        OP_START: begin
          rca_nxt  = '0;
          ba_nxt   = 1'b0;
          size_nxt = '0;
          hcs_nxt  = 1'b0;
          ms_nxt   = '0;
          app_nxt  = 1'b0;
          if (!item.card_sense) begin
            go_fail = 1'b1;
          end else begin
            pwr_nxt   = 1'b1;
            phase_nxt = PH_CMD0;
            att_nxt   = '0;
            res_emit  = 1'b1;
            r_idx     = CMD_GO_IDLE;
          end
        end
        OP_TICK: begin
          if (phase_r == PH_ACMD41 && ms_r != '1) ms_nxt = ms_r + MS_COUNTER_BITS'(1);
        end
        OP_DONE: begin
          unique case (phase_r)
            PH_IDLE: ;
            PH_CMD0: begin
              if (rc == RC_OK) begin
                phase_nxt = PH_CMD8;
                att_nxt   = '0;
                res_emit  = 1'b1;
                r_idx     = CMD_SEND_IF;
                r_arg     = CHECK_PATTERN;
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_GO_IDLE;
                end else go_fail = 1'b1;
              end
            end
            PH_CMD8: begin
              if (rc == RC_OK) begin
                if (w1 != CHECK_PATTERN) go_fail = 1'b1;
                else begin
                  hcs_nxt = 1'b1;
                  ms_nxt  = '0;
                  go_app  = 1'b1;
                end
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_SEND_IF;
                  r_arg    = CHECK_PATTERN;
                end else if (rc != RC_TMO) begin
                  go_fail = 1'b1;
                end else begin
                  // no answer to the voltage check: version 1 card
                  hcs_nxt = 1'b0;
                  ms_nxt  = '0;
                  go_app  = 1'b1;
                end
              end
            end
            PH_ACMD41, PH_ACMD6: begin
              // prefix wants any success; acmd41 answers R3 without crc, so crc fail
              if ((app_r && rc != RC_OK) ||
                  (!app_r && phase_r == PH_ACMD41 && rc != RC_CRC) ||
                  (!app_r && phase_r == PH_ACMD6 && rc != RC_OK)) begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  app_nxt  = 1'b1;
                  res_emit = 1'b1;
                  r_idx    = CMD_APP;
                  r_arg    = {rca_r, 16'h0};
                end else begin
                  app_nxt = 1'b0;
                  if (phase_r == PH_ACMD41) begin
                    if (deadline) go_fail = 1'b1;
                    else go_app = 1'b1;
                  end else go_fail = 1'b1;
                end
              end else if (app_r) begin
                app_nxt  = 1'b0;
                res_emit = 1'b1;
                if (phase_r == PH_ACMD41) begin
                  r_idx = CMD_OP_COND;
                  r_arg = OCR_VOLT | (hcs_r ? OCR_HCS : 32'h0);
                end else begin
                  r_idx = CMD_BUS_WIDTH;
                  r_arg = ARG_BUS_4BIT;
                end
              end else if (phase_r == PH_ACMD6) begin
                phase_nxt = PH_IDLE;
                res_emit  = 1'b1;
                r_kind    = KIND_OK;
              end else if (w1[OCR_BUSY_BIT]) begin
                ba_nxt    = w1[OCR_HCS_BIT];
                phase_nxt = PH_CMD2;
                att_nxt   = '0;
                res_emit  = 1'b1;
                r_idx     = CMD_ALL_CID;
              end else begin
                // card still busy: next poll unless the deadline passed
                if (deadline) go_fail = 1'b1;
                else go_app = 1'b1;
              end
            end
            PH_CMD2: begin
              if (rc == RC_OK) begin
                phase_nxt = PH_CMD3;
                att_nxt   = '0;
                res_emit  = 1'b1;
                r_idx     = CMD_REL_ADDR;
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_ALL_CID;
                end else go_fail = 1'b1;
              end
            end
            PH_CMD3: begin
              if (rc == RC_OK) rca_nxt = w1[31:16];
              if (rc == RC_OK && w1[31:16] != 16'h0) begin
                phase_nxt = PH_CMD9;
                att_nxt   = '0;
                res_emit  = 1'b1;
                r_idx     = CMD_SEND_CSD;
                r_arg     = {w1[31:16], 16'h0};
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_REL_ADDR;
                end else go_fail = 1'b1;
              end
            end
            PH_CMD9: begin
              if (rc == RC_OK) begin
                if (w1[31:30] == CSD_V1 || w1[31:30] == CSD_V2) begin
                  size_nxt  = (w1[31:30] == CSD_V1) ?
                              csd_v1_blocks(item.resp_word_two, item.resp_word_three) :
                              csd_v2_blocks(item.resp_word_two, item.resp_word_three);
                  phase_nxt = PH_CMD7;
                  att_nxt   = '0;
                  res_emit  = 1'b1;
                  r_idx     = CMD_SELECT;
                  r_arg     = {rca_r, 16'h0};
                end else go_fail = 1'b1;
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_SEND_CSD;
                  r_arg    = {rca_r, 16'h0};
                end else go_fail = 1'b1;
              end
            end
            PH_CMD7: begin
              if (rc == RC_OK) begin
                go_app = 1'b1;
                app_ph = PH_ACMD6;
              end else begin
                att_nxt = att_inc;
                if (retry_ok) begin
                  res_emit = 1'b1;
                  r_idx    = CMD_SELECT;
                  r_arg    = {rca_r, 16'h0};
                end else go_fail = 1'b1;
              end
            end
            default: phase_nxt = PH_IDLE;
          endcase
        end
        default: ;
      endcase

      // start of an app command pair: cmd55 with the card address
      if (go_app) begin
        phase_nxt = app_ph;
        att_nxt   = '0;
        app_nxt   = 1'b1;
        res_emit  = 1'b1;
        r_kind    = KIND_CMD;
        r_idx     = CMD_APP;
        r_arg     = {rca_nxt, 16'h0};
      end
      if (go_fail) begin
        phase_nxt = PH_IDLE;
        pwr_nxt   = 1'b0;
        app_nxt   = 1'b0;
        res_emit  = 1'b1;
        r_kind    = KIND_FAIL;
        r_idx     = '0;
        r_arg     = '0;
      end
    end
  end

  always_comb begin
    res.kind            = r_kind;
    res.cmd_index       = r_idx;
    res.cmd_arg         = r_arg;
    res.power_on        = pwr_nxt;
    res.card_addr       = rca_nxt;
    res.high_capacity   = ba_nxt;
    res.capacity_blocks = size_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sdi_out_stage.sv =====
// sdi_out_stage: result register with response type and bus width decode
// depends on sdi_pkg for the result struct and resp_kind
`default_nettype none

module sdi_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          res_emit,
  input  wire sdi_pkg::res_t res,
  output logic               res_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_kind,
  output logic [5:0]         out_cmd_index,
  output logic [31:0]        out_cmd_arg,
  output logic [1:0]         out_resp_type,
  output logic               out_power_on,
  output logic               out_wide_bus,
  output logic [15:0]        out_card_addr,
  output logic               out_high_capacity,
  output logic [32:0]        out_capacity_blocks
);
  import sdi_pkg::*;

  logic       valid_r, valid_nxt;
  res_t       res_r;
  logic [1:0] rtype_r;

  assign res_ready = !valid_r || !out_stall;

  always_comb begin
    if (res_emit) valid_nxt = 1'b1;
    else if (out_stall) valid_nxt = valid_r;
    else valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      res_r   <= res;
      rtype_r <= (res.kind == KIND_CMD) ? resp_kind(res.cmd_index) : RESP_NONE;
    end
  end

  assign out_valid           = valid_r;
  assign out_kind            = res_r.kind;
  assign out_cmd_index       = res_r.cmd_index;
  assign out_cmd_arg         = res_r.cmd_arg;
  assign out_resp_type       = rtype_r;
  assign out_power_on        = res_r.power_on;
  assign out_wide_bus        = (res_r.kind == KIND_OK);
  assign out_card_addr       = res_r.card_addr;
  assign out_high_capacity   = res_r.high_capacity;
  assign out_capacity_blocks = res_r.capacity_blocks;

endmodule

`default_nettype wire

// ===== hw/rtl/sd_card_init_sequencer.sv =====
// sd_card_init_sequencer: top level of the host-side sd card bring-up sequencer
// depends on sdi_pkg, sdi_in_stage, sdi_core and sdi_out_stage
//
//  channel | direction | handshake          | beat contents
//  --------+-----------+--------------------+---------------------------------------------
//  in_     | in        | in_valid/in_stall  | operation, card detect, flags, 3 resp words
//  out_    | out       | out_valid/out_stall| kind, command, resp type, power, card info
//  cfg_    | in        | cfg_valid/cfg_ready| register index, write data
//
// one event beat per cycle sustained while out_stall is low; a beat lands in the input
// register when accepted, and its result goes to the result register when the core takes it
// the rate is set by the phase/attempt state loop, which decides one event per cycle
// reset (rst_n low at a clock edge) empties both registers, sends the sequencer idle
// with power off and loads max_attempts = 5, op_cond_timeout_ms = 1000
// while a result waits under out_stall the held event waits too; in_stall rises only then
// cfg writes are always taken (cfg_ready is tied high)
`default_nettype none

module sd_card_init_sequencer #(
  parameter int unsigned MS_COUNTER_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // event input
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_operation,
  input  wire logic                           in_card_sense,
  input  wire logic [3:0]                     in_status_flags,
  input  wire logic [31:0]                    in_resp_word_one,
  input  wire logic [31:0]                    in_resp_word_two,
  input  wire logic [31:0]                    in_resp_word_three,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          out_kind,
  output logic [5:0]                          out_cmd_index,
  output logic [31:0]                         out_cmd_arg,
  output logic [1:0]                          out_resp_type,
  output logic                                out_power_on,
  output logic                                out_wide_bus,
  output logic [15:0]                         out_card_addr,
  output logic                                out_high_capacity,
  output logic [32:0]                         out_capacity_blocks,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sdi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sdi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdi_pkg::*;

  in_item_t in_item, item;
  logic     item_valid, take;
  logic     res_emit, res_ready;
  res_t     res;

  assign cfg_ready = 1'b1;

  // pack the event fields into one beat
  always_comb begin
    in_item.operation       = in_operation;
    in_item.card_sense      = in_card_sense;
    in_item.status_flags    = in_status_flags;
    in_item.resp_word_one   = in_resp_word_one;
    in_item.resp_word_two   = in_resp_word_two;
    in_item.resp_word_three = in_resp_word_three;
  end

  sdi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // decision logic: one event moves the sequence by at most one command
  sdi_core #(
    .MS_COUNTER_BITS (MS_COUNTER_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .res_ready  (res_ready),
    .take       (take),
    .res_emit   (res_emit),
    .res        (res)
  );

  sdi_out_stage u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .res_emit            (res_emit),
    .res                 (res),
    .res_ready           (res_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_cmd_index       (out_cmd_index),
    .out_cmd_arg         (out_cmd_arg),
    .out_resp_type       (out_resp_type),
    .out_power_on        (out_power_on),
    .out_wide_bus        (out_wide_bus),
    .out_card_addr       (out_card_addr),
    .out_high_capacity   (out_high_capacity),
    .out_capacity_blocks (out_capacity_blocks)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sdi_checker.sv =====
// sdi_checker: port-level assertions for the sd card init sequencer, bound to the top level
// depends on sdi_pkg for result kind and response type codes
`default_nettype none

module sdi_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_kind,
  input wire logic [5:0]  out_cmd_index,
  input wire logic [31:0] out_cmd_arg,
  input wire logic [1:0]  out_resp_type,
  input wire logic        out_power_on,
  input wire logic        out_wide_bus
);
  import sdi_pkg::*;

  // command fields are blank on ok and fail beats
  a_blank_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_CMD) |->
      (out_cmd_index == '0 && out_cmd_arg == '0 && out_resp_type == RESP_NONE))
    else $error("command fields not blank on a status beat");

  // failure always drops card power
  a_fail_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_FAIL) |-> !out_power_on)
    else $error("fail beat with power on");

  // commands go out only to a powered card
  a_cmd_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_CMD) |-> out_power_on)
    else $error("command issued with power off");

  // four-bit bus only reported together with the ok beat
  a_wide_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wide_bus == (out_kind == KIND_OK)))
    else $error("wide bus does not match ok result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_cmd_arg)))
    else $error("stalled result beat changed");

endmodule

bind sd_card_init_sequencer sdi_checker u_sdi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_cmd_index (out_cmd_index),
  .out_cmd_arg   (out_cmd_arg),
  .out_resp_type (out_resp_type),
  .out_power_on  (out_power_on),
  .out_wide_bus  (out_wide_bus)
);

`default_nettype wire

// ===== bench/sd_card_init_sequencer_tb.sv =====
// sd_card_init_sequencer_tb: self-checking bench for the sd card bring-up sequencer
// depends on sdi_pkg and sd_card_init_sequencer; a scoreboard class predicts each result
// beat while plain tasks drive directed events, then mostly well-formed random bring-ups
`timescale 1ns / 1ps

module sd_card_init_sequencer_tb;
  import sdi_pkg::*;

  // operation code the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [15:0] POLL_MS_TOP   = 16'hFFFF; // ms counter saturates here
  localparam int unsigned RUN_LIMIT     = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 12;       // covers the input-to-result register delay plus margin
  localparam int unsigned RANDOM_ROUNDS = 8;
  localparam int unsigned ROUND_BEATS   = 200;

  // one result beat, every output field of the block
  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [1:0]  resp_type;
    logic        power_on;
    logic        wide_bus;
    logic [15:0] card_addr;
    logic        high_capacity;
    logic [32:0] capacity_blocks;
  } seq_result_t;

  // mirror of the sequencer: register copies, bring-up state, queued result beats
  class init_scoreboard;
    logic [3:0]  max_tries;
    logic [15:0] poll_budget_ms;
    phase_t      seq_phase;
    logic [3:0]  tries;
    bit          app_prefix;
    logic [15:0] poll_ms;
    bit          host_hcs;
    logic [15:0] rca;
    bit          block_mode;
    logic [32:0] size_blocks;
    bit          power;
    seq_result_t pending_q[$];
    int unsigned errors;

    function new();
      max_tries      = MAX_ATTEMPTS_RST;
      poll_budget_ms = OP_TIMEOUT_RST;
      seq_phase      = PH_IDLE;
      tries          = '0;
      app_prefix     = 1'b0;
      poll_ms        = '0;
      host_hcs       = 1'b0;
      rca            = '0;
      block_mode     = 1'b0;
      size_blocks    = '0;
      power          = 1'b0;
      errors         = 0;
    endfunction

    function logic [1:0] resp_for(logic [5:0] idx);
      case (idx)
        CMD_GO_IDLE: return RESP_NONE;
        CMD_ALL_CID, CMD_SEND_CSD, CMD_SEND_CID: return RESP_LONG;
        default: return RESP_SHORT;
      endcase
    endfunction

    function void post(kind_t k, logic [5:0] idx, logic [31:0] arg);
      seq_result_t r;
      r.kind            = k;
      r.cmd_index       = (k == KIND_CMD) ? idx : '0;
      r.cmd_arg         = (k == KIND_CMD) ? arg : '0;
      r.resp_type       = (k == KIND_CMD) ? resp_for(idx) : RESP_NONE;
      r.power_on        = power;
      r.wide_bus        = (k == KIND_OK);
      r.card_addr       = rca;
      r.high_capacity   = block_mode;
      r.capacity_blocks = size_blocks;
      pending_q.push_back(r);
    endfunction

    function logic [31:0] rca_arg();
      return {rca, 16'h0000};
    endfunction

    function int unsigned try_limit();
      return (max_tries == 0) ? 1 : max_tries;
    endfunction

    function void abort();
      seq_phase  = PH_IDLE;
      power      = 1'b0;
      app_prefix = 1'b0;
      post(KIND_FAIL, '0, '0);
    endfunction

    function void go(phase_t ph, logic [5:0] idx, logic [31:0] arg);
      seq_phase = ph;
      tries     = '0;
      post(KIND_CMD, idx, arg);
    endfunction

    function void go_app(phase_t ph);
      seq_phase  = ph;
      tries      = '0;
      app_prefix = 1'b1;
      post(KIND_CMD, CMD_APP, rca_arg());
    endfunction

    function void retry(logic [5:0] idx, logic [31:0] arg);
      tries = tries + 4'd1;
      if (tries < try_limit()) post(KIND_CMD, idx, arg);
      else abort();
    endfunction

    function void poll_or_give_up();
      if (poll_ms >= poll_budget_ms) abort();
      else go_app(PH_ACMD41);
    endfunction

    // CMD55 + application command pair did not end as it should
    function void app_retry();
      tries = tries + 4'd1;
      if (tries < try_limit()) begin
        app_prefix = 1'b1;
        post(KIND_CMD, CMD_APP, rca_arg());
      end else begin
        app_prefix = 1'b0;
        if (seq_phase == PH_ACMD41) poll_or_give_up();
        else abort();
      end
    endfunction

    function void take_csd(logic [31:0] w1, logic [31:0] w2, logic [31:0] w3);
      logic [63:0] c_size;
      logic [63:0] bytes;
      int unsigned mult_sh;
      int unsigned len_sh;
      case (w1[31:30])
        CSD_V1: begin
          c_size      = {52'd0, w2[9:0], w3[31:30]};
          mult_sh     = w3[17:15] + 2;
          len_sh      = w2[19:16];
          bytes       = ((c_size + 64'd1) << mult_sh) << len_sh;
          size_blocks = bytes[41:9];
        end
        CSD_V2: begin
          c_size      = {42'd0, w2[5:0], w3[31:16]};
          bytes       = (c_size + 64'd1) << 10;
          size_blocks = bytes[32:0];
        end
        default: begin
          abort();
          return;
        end
      endcase
      go(PH_CMD7, CMD_SELECT, rca_arg());
    endfunction

    function void on_completion(in_item_t it);
      res_class_t  rc;
      logic [31:0] w1;
      bit          ok;
      w1 = it.resp_word_one;
      if (it.status_flags[1:0] != 2'b00) rc = RC_OK;
      else if (it.status_flags[2])       rc = RC_TMO;
      else if (it.status_flags[3])       rc = RC_CRC;
      else                               rc = RC_UNK;
      ok = (rc == RC_OK);
      case (seq_phase)
        PH_CMD0: begin
          if (ok) go(PH_CMD8, CMD_SEND_IF, CHECK_PATTERN);
          else retry(CMD_GO_IDLE, '0);
        end
        PH_CMD8: begin
          if (ok) begin
            if (w1 != CHECK_PATTERN) abort();
            else begin
              host_hcs = 1'b1;
              poll_ms  = '0;
              go_app(PH_ACMD41);
            end
          end else begin
            tries = tries + 4'd1;
            if (tries < try_limit()) post(KIND_CMD, CMD_SEND_IF, CHECK_PATTERN);
            else if (rc != RC_TMO) abort();
            else begin
              // no answer to the voltage check: version 1 card, no hcs request
              host_hcs = 1'b0;
              poll_ms  = '0;
              go_app(PH_ACMD41);
            end
          end
        end
        PH_ACMD41: begin
          if (app_prefix) begin
            if (!ok) app_retry();
            else begin
              app_prefix = 1'b0;
              post(KIND_CMD, CMD_OP_COND, OCR_VOLT | (host_hcs ? OCR_HCS : 32'd0));
            end
          end else if (rc != RC_CRC) app_retry();
          else if (w1[OCR_BUSY_BIT]) begin
            block_mode = w1[OCR_HCS_BIT];
            go(PH_CMD2, CMD_ALL_CID, '0);
          end else poll_or_give_up();
        end
        PH_CMD2: begin
          if (ok) go(PH_CMD3, CMD_REL_ADDR, '0);
          else retry(CMD_ALL_CID, '0);
        end
        PH_CMD3: begin
          if (ok) rca = w1[31:16];
          if (ok && rca != 16'd0) go(PH_CMD9, CMD_SEND_CSD, rca_arg());
          else retry(CMD_REL_ADDR, '0);
        end
        PH_CMD9: begin
          if (ok) take_csd(w1, it.resp_word_two, it.resp_word_three);
          else retry(CMD_SEND_CSD, rca_arg());
        end
        PH_CMD7: begin
          if (ok) go_app(PH_ACMD6);
          else retry(CMD_SELECT, rca_arg());
        end
        PH_ACMD6: begin
          if (!ok) app_retry();
          else if (app_prefix) begin
            app_prefix = 1'b0;
            post(KIND_CMD, CMD_BUS_WIDTH, ARG_BUS_4BIT);
          end else begin
            seq_phase = PH_IDLE;
            post(KIND_OK, '0, '0);
          end
        end
        default: seq_phase = PH_IDLE;
      endcase
    endfunction

    // returns 1 when the beat did something: a result or a counted tick
    function bit note_input(in_item_t it);
      case (it.operation)
        OP_START: begin
          rca         = '0;
          block_mode  = 1'b0;
          size_blocks = '0;
          host_hcs    = 1'b0;
          poll_ms     = '0;
          app_prefix  = 1'b0;
          if (!it.card_sense) abort();
          else begin
            power = 1'b1;
            go(PH_CMD0, CMD_GO_IDLE, '0);
          end
          return 1'b1;
        end
        OP_TICK: begin
          if (seq_phase == PH_ACMD41 && poll_ms != POLL_MS_TOP) begin
            poll_ms = poll_ms + 16'd1;
            return 1'b1;
          end
        end
        OP_DONE: begin
          if (seq_phase != PH_IDLE) begin
            on_completion(it);
            return 1'b1;
          end
        end
        default: ;
      endcase
      return 1'b0;
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 60)
          $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(seq_result_t got);
      seq_result_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 60)
          $display("%0t: result beat with nothing expected, expected none, actual kind %0d cmd %0d",
                   $time, got.kind, got.cmd_index);
        return;
      end
      want = pending_q.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("cmd_index", want.cmd_index, got.cmd_index);
      compare_field("cmd_arg", want.cmd_arg, got.cmd_arg);
      compare_field("resp_type", want.resp_type, got.resp_type);
      compare_field("power_on", want.power_on, got.power_on);
      compare_field("wide_bus", want.wide_bus, got.wide_bus);
      compare_field("card_addr", want.card_addr, got.card_addr);
      compare_field("high_capacity", want.high_capacity, got.high_capacity);
      compare_field("capacity_blocks", want.capacity_blocks, got.capacity_blocks);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_operation;
  logic                  in_card_sense;
  logic [3:0]            in_status_flags;
  logic [31:0]           in_resp_word_one;
  logic [31:0]           in_resp_word_two;
  logic [31:0]           in_resp_word_three;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_kind;
  logic [5:0]            out_cmd_index;
  logic [31:0]           out_cmd_arg;
  logic [1:0]            out_resp_type;
  logic                  out_power_on;
  logic                  out_wide_bus;
  logic [15:0]           out_card_addr;
  logic                  out_high_capacity;
  logic [32:0]           out_capacity_blocks;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  init_scoreboard sb = new();

  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned counted     = 0;  // beats of the current round that did something
  int unsigned stall_mode  = 0;
  int unsigned stall_span  = 0;
  int unsigned stall_count = 0;

  sd_card_init_sequencer u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_card_sense       (in_card_sense),
    .in_status_flags     (in_status_flags),
    .in_resp_word_one    (in_resp_word_one),
    .in_resp_word_two    (in_resp_word_two),
    .in_resp_word_three  (in_resp_word_three),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_cmd_index       (out_cmd_index),
    .out_cmd_arg         (out_cmd_arg),
    .out_resp_type       (out_resp_type),
    .out_power_on        (out_power_on),
    .out_wide_bus        (out_wide_bus),
    .out_card_addr       (out_card_addr),
    .out_high_capacity   (out_high_capacity),
    .out_capacity_blocks (out_capacity_blocks),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit: well above the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall: the mode is redrawn at random whenever its span runs out
  // mode 0 never stalls, 1 light random, 2 fixed 2-of-5 pattern, 3 heavy random
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(20, 150);
    end else begin
      stall_span = stall_span - 1;
    end
    stall_count = (stall_count == 4) ? 0 : stall_count + 1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 25);
      2: out_stall <= (stall_count < 2);
      default: out_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  // every result beat taken at a rising edge is checked against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_kind, out_cmd_index, out_cmd_arg, out_resp_type, out_power_on,
                       out_wide_bus, out_card_addr, out_high_capacity, out_capacity_blocks});
  end

  // present one event beat from the falling edge and hold it until taken;
  // the prediction is updated at the accepting edge
  task automatic send_event(input in_item_t it);
    @(negedge clk);
    in_valid           <= 1'b1;
    in_operation       <= it.operation;
    in_card_sense      <= it.card_sense;
    in_status_flags    <= it.status_flags;
    in_resp_word_one   <= it.resp_word_one;
    in_resp_word_two   <= it.resp_word_two;
    in_resp_word_three <= it.resp_word_three;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_input(it)) counted++;
  endtask

  // sender bursts: back-to-back beats, then a short gap with valid low
  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 6);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic drive_event(input logic [1:0] op, input logic present, input logic [3:0] flags,
                             input logic [31:0] w1, input logic [31:0] w2 = '0,
                             input logic [31:0] w3 = '0);
    in_item_t it;
    it.operation       = op;
    it.card_sense      = present;
    it.status_flags    = flags;
    it.resp_word_one   = w1;
    it.resp_word_two   = w2;
    it.resp_word_three = w3;
    send_event(it);
    pace();
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MAX_ATTEMPTS: sb.max_tries = value[3:0];
      CFG_OP_TIMEOUT:   sb.poll_budget_ms = value;
      default: ;
    endcase
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every predicted beat, then let beats with no result drain
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // next random event, shaped by where the sequencer stands so most bring-ups run deep
  function automatic in_item_t make_event();
    in_item_t    it;
    int unsigned dice;
    int unsigned roll;
    bit          op_cond_reply;
    it.operation       = OP_DONE;
    it.card_sense      = 1'($urandom_range(0, 1));
    it.status_flags    = 4'($urandom_range(0, 15));
    it.resp_word_one   = $urandom;
    it.resp_word_two   = $urandom;
    it.resp_word_three = $urandom;
    dice = $urandom_range(0, 99);

    // idle: mostly starts, some stray completions, ticks and the unused code
    if (sb.seq_phase == PH_IDLE) begin
      if (dice < 80) begin
        it.operation  = OP_START;
        it.card_sense = ($urandom_range(0, 9) != 0);
      end else if (dice < 88) it.operation = OP_DONE;
      else if (dice < 94) it.operation = OP_TICK;
      else it.operation = OP_UNUSED;
      return it;
    end

    // busy: a little noise, ticks mostly while polling for the card to get ready
    if (dice < 1) begin
      it.operation  = OP_START;
      it.card_sense = 1'b1;
      return it;
    end
    if (dice < 2) begin
      it.operation = OP_UNUSED;
      return it;
    end
    if ((sb.seq_phase == PH_ACMD41 && dice < 40) || dice < 5) begin
      it.operation = OP_TICK;
      return it;
    end

    // completion: mostly the answer the current step wants
    op_cond_reply = (sb.seq_phase == PH_ACMD41) && !sb.app_prefix;
    roll = $urandom_range(0, 99);
    if (roll < 86) begin
      if (op_cond_reply) it.status_flags = 4'b1000;
      else it.status_flags = {2'($urandom_range(0, 3)), 2'($urandom_range(1, 3))};
    end else if (roll < 93) it.status_flags = {1'($urandom_range(0, 1)), 3'b100};
    else if (roll < 97) it.status_flags = 4'b1000;
    else it.status_flags = 4'b0000;

    roll = $urandom_range(0, 99);
    case (sb.seq_phase)
      PH_CMD8: if (roll < 90) it.resp_word_one = CHECK_PATTERN;
      PH_ACMD41: it.resp_word_one[OCR_BUSY_BIT] = (roll < 40);
      PH_CMD3: if (roll < 15) it.resp_word_one[31:16] = '0;
      PH_CMD9: begin
        if (roll < 45) it.resp_word_one[31:30] = CSD_V1;
        else if (roll < 90) it.resp_word_one[31:30] = CSD_V2;
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    logic [3:0]  round_tries;
    logic [15:0] round_budget;

    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_operation       = OP_START;
    in_card_sense      = 1'b0;
    in_status_flags    = '0;
    in_resp_word_one   = '0;
    in_resp_word_two   = '0;
    in_resp_word_three = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_MAX_ATTEMPTS;
    cfg_data           = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed part, reset register values (5 attempts, 1000 ms)
    drive_event(OP_DONE, 1'b1, 4'h1, '0);                 // completion while idle: ignored
    drive_event(OP_UNUSED, 1'b1, 4'hF, '1, '1, '1);       // unused operation: ignored
    drive_event(OP_TICK, 1'b0, 4'h0, '0);                 // tick while idle: ignored
    drive_event(OP_START, 1'b0, 4'h0, '0);                // no card: fail at once
    drive_event(OP_START, 1'b1, 4'h0, '0);                // power up, CMD0
    drive_event(OP_DONE, 1'b1, 4'h0, '0);                 // no flag: unknown error, retry
    drive_event(OP_DONE, 1'b1, 4'hF, '0);                 // all flags: success ranks first
    repeat (5) drive_event(OP_DONE, 1'b0, 4'h4, '1, '1, '1); // CMD8 timeouts: version 1 card
    drive_event(OP_DONE, 1'b1, 4'h2, '0);                 // CMD55 sent, ACMD41 next
    drive_event(OP_TICK, 1'b1, 4'h0, '0);
    drive_event(OP_DONE, 1'b1, 4'h8, 32'h7FFF_FFFF);      // card still busy: poll again
    drive_event(OP_DONE, 1'b1, 4'h1, '0);
    drive_event(OP_DONE, 1'b1, 4'h8, 32'hC0FF_8000);      // ready with hcs set
    drive_event(OP_DONE, 1'b1, 4'h3, '0);                 // CMD2 done
    drive_event(OP_DONE, 1'b1, 4'h1, 32'h0000_FFFF);      // zero card address: CMD3 again
    drive_event(OP_DONE, 1'b1, 4'h1, 32'hFFFF_0000);      // largest card address
    drive_event(OP_DONE, 1'b1, 4'h1, 32'h0000_0000, '1, '1); // version 1 csd, all fields max
    drive_event(OP_DONE, 1'b1, 4'h1, '0);                 // CMD7 done
    drive_event(OP_DONE, 1'b1, 4'h1, '0);                 // CMD55 for ACMD6
    drive_event(OP_DONE, 1'b1, 4'h1, '0);                 // bus width set: init ok
    drive_event(OP_START, 1'b1, 4'h0, '0);
    drive_event(OP_DONE, 1'b1, 4'h1, '0);
    drive_event(OP_START, 1'b1, 4'h0, '0);                // start while busy: restart

    // random rounds, each under its own register setting
    for (int unsigned round = 0; round < RANDOM_ROUNDS; round++) begin
      settle();
      case (round)
        0: begin round_tries = 4'd15; round_budget = 16'hFFFF; end
        1: begin round_tries = 4'd1;  round_budget = 16'd1;    end
        2: begin round_tries = 4'd0;  round_budget = 16'd2;    end
        3: begin round_tries = 4'd3;  round_budget = 16'd40;   end
        default: begin
          round_tries  = 4'($urandom_range(1, 15));
          round_budget = 16'($urandom_range(1, 12));
        end
      endcase
      write_cfg(CFG_MAX_ATTEMPTS, {12'd0, round_tries});
      write_cfg(CFG_OP_TIMEOUT, round_budget);
      counted = 0;
      while (counted < ROUND_BEATS) begin
        send_event(make_event());
        pace();
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
